@@ rtl/mbd_pkg.sv @@
// Package for the motion bite detector.
// Holds the configuration port types, register indexes and reset values.
// No dependencies.
package mbd_pkg;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
    typedef logic [CFG_DATA_W-1:0]  cfg_data_t;

    // Register indexes
    localparam cfg_index_t CFG_MOTION_THRESHOLD = 3'd0;
    localparam cfg_index_t CFG_RUN_LENGTH       = 3'd1;
    localparam cfg_index_t CFG_HOLD_TICKS       = 3'd2;
    localparam cfg_index_t CFG_LIFT_LEVEL       = 3'd3;
    localparam cfg_index_t CFG_END_TICKS        = 3'd4;

    // Field widths
    localparam int SAMPLE_W    = 16;
    localparam int THRESHOLD_W = 12;
    localparam int RUN_W       = 4;
    localparam int HOLD_W      = 8;
    localparam int END_W       = 10;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    // Register reset values
    localparam logic [THRESHOLD_W-1:0] MOTION_THRESHOLD_RST = 12'd29;
    localparam logic [RUN_W-1:0]       RUN_LENGTH_RST       = 4'd3;
    localparam logic [HOLD_W-1:0]      HOLD_TICKS_RST       = 8'd50;
    localparam sample_t                LIFT_LEVEL_RST       = -16'sd4096;
    localparam logic [END_W-1:0]       END_TICKS_RST        = 10'd300;

    // Saturation value of the end counter
    localparam logic [END_W-1:0] END_COUNT_MAX = '1;

endpackage

@@ rtl/motion_bite_detector.sv @@
// Motion bite detector: moving-window high-pass change test, hit run, bite hold
// and lift-off end counter on a stream of Z-axis samples.
// Depends on mbd_pkg.
//
// The item is taken into the input register at acceptance; its flags reach the
// result register when the state update advances, which waits while the result
// register is full and not drained. Throughput: one item per cycle while results
// drain, set by the single state update stage; an item is taken while a result waits.
// Reset (rst_n, asynchronous, active low) clears all filter and detector state
// to zero, empties both stages and loads the register reset values.
module motion_bite_detector #(
    parameter int WINDOW = 5
) (
    input  logic               clk,
    input  logic               rst_n,

    // Configuration write port
    input  logic               cfg_wr_en,
    input  mbd_pkg::cfg_index_t cfg_index,
    input  mbd_pkg::cfg_data_t  cfg_data,

    // Sample input channel
    input  logic               in_valid,
    output logic               in_ready,
    input  mbd_pkg::sample_t   sample_z,

    // Result output channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic               bite,
    output logic               all_off,
    output logic               motion_hit
);

    import mbd_pkg::*;

    // The window sum of WINDOW 16-bit samples needs clog2(WINDOW) growth bits;
    // one more bit keeps the sum signed with margin.
    localparam int SUM_W     = SAMPLE_W + 1 + $clog2(WINDOW);
    // The change term 5*S - 9*P + 4*Q grows by at most a factor of 18.
    localparam int T_W       = SUM_W + 6;
    // The limit is 5 * WINDOW * motion_threshold.
    localparam int LIMIT_MUL = 5 * WINDOW;
    localparam int LIM_W     = THRESHOLD_W + $clog2(LIMIT_MUL + 1);

    // ------------------------------------------------------------------
    // Configuration registers. Writes must arrive only while the block is idle;
    // the block itself does not enforce this.
    logic [THRESHOLD_W-1:0] motion_threshold_reg;
    logic [RUN_W-1:0]       run_length_reg;
    logic [HOLD_W-1:0]      hold_ticks_reg;
    sample_t                lift_level_reg;
    logic [END_W-1:0]       end_ticks_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motion_threshold_reg <= MOTION_THRESHOLD_RST;
            run_length_reg       <= RUN_LENGTH_RST;
            hold_ticks_reg       <= HOLD_TICKS_RST;
            lift_level_reg       <= LIFT_LEVEL_RST;
            end_ticks_reg        <= END_TICKS_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_MOTION_THRESHOLD: motion_threshold_reg <= cfg_data[THRESHOLD_W-1:0];
                CFG_RUN_LENGTH:       run_length_reg       <= cfg_data[RUN_W-1:0];
                CFG_HOLD_TICKS:       hold_ticks_reg       <= cfg_data[HOLD_W-1:0];
                CFG_LIFT_LEVEL:       lift_level_reg       <= sample_t'(cfg_data[SAMPLE_W-1:0]);
                CFG_END_TICKS:        end_ticks_reg        <= cfg_data[END_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control. The input register advances into the state update
    // whenever the result register is empty or is being drained this cycle.
    // ------------------------------------------------------------------
    logic    s1_valid_reg;
    sample_t s1_sample_reg;
    logic    out_valid_reg;
    logic    advance;

    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_sample_reg <= sample_z;
        end
    end

    // ------------------------------------------------------------------
    // Detector state.
    // The window is kept as a shift line of the last WINDOW samples plus a
    // running sum, so the new sum is the old sum minus the sample that drops
    // out plus the new one. This gives the same sums as summing a ring.
    // ------------------------------------------------------------------
    sample_t                  tap_reg [WINDOW];
    logic signed [SUM_W-1:0]  sum_prev_reg;
    logic signed [SUM_W-1:0]  sum_prev2_reg;
    logic [RUN_W-1:0]         run_count_reg;
    logic                     bite_flag_reg;
    logic [HOLD_W-1:0]        hold_count_reg;
    logic [END_W-1:0]         end_count_reg;
    logic                     off_flag_reg;

    logic signed [SUM_W-1:0]  sum_next;
    logic signed [T_W-1:0]    s_ext;
    logic signed [T_W-1:0]    p_ext;
    logic signed [T_W-1:0]    q_ext;
    logic signed [T_W-1:0]    change;
    logic [T_W-1:0]           change_abs;
    logic [LIM_W-1:0]         limit;
    logic                     hit_next;
    logic                     above;
    logic                     off_next;
    logic [END_W-1:0]         end_count_next;
    logic [RUN_W-1:0]         run_inc;
    logic [RUN_W-1:0]         run_count_next;
    logic                     bite_mid;
    logic                     bite_next;
    logic [HOLD_W-1:0]        hold_count_next;

    always_comb
    begin
        // End counter: advances while the device is lifted above lift_level.
        above          = s1_sample_reg > lift_level_reg;
        off_next       = off_flag_reg;
        end_count_next = end_count_reg;
        if (above)
        begin
            if (end_count_reg > end_ticks_reg)
            begin
                off_next = 1'b1;
            end
            if (end_count_reg != END_COUNT_MAX)
            begin
                end_count_next = end_count_reg + 1'b1;
            end
        end
        else
        begin
            off_next = 1'b0;
        end

        // Window sum and the scaled high-pass change test.
        sum_next = sum_prev_reg
                 - {{(SUM_W-SAMPLE_W){tap_reg[WINDOW-1][SAMPLE_W-1]}}, tap_reg[WINDOW-1]}
                 + {{(SUM_W-SAMPLE_W){s1_sample_reg[SAMPLE_W-1]}}, s1_sample_reg};
        s_ext  = {{(T_W-SUM_W){sum_next[SUM_W-1]}}, sum_next};
        p_ext  = {{(T_W-SUM_W){sum_prev_reg[SUM_W-1]}}, sum_prev_reg};
        q_ext  = {{(T_W-SUM_W){sum_prev2_reg[SUM_W-1]}}, sum_prev2_reg};
        change = (s_ext <<< 2) + s_ext - ((p_ext <<< 3) + p_ext) + (q_ext <<< 2);
        change_abs = change[T_W-1] ? T_W'(-change) : T_W'(change);
        limit      = LIM_W'(motion_threshold_reg) * LIM_W'(LIMIT_MUL);
        hit_next   = change_abs > T_W'(limit);

        // Run of hits. The count wraps at its width like the original counter.
        run_inc        = run_count_reg + 1'b1;
        run_count_next = '0;
        bite_mid       = bite_flag_reg;
        if (hit_next)
        begin
            if (run_inc >= run_length_reg)
            begin
                bite_mid = 1'b1;
            end
            else
            begin
                run_count_next = run_inc;
            end
        end

        // Bite hold runs only while indicators are not forced off.
        bite_next       = bite_mid;
        hold_count_next = hold_count_reg;
        if (!off_next && bite_mid)
        begin
            if (hold_count_reg >= hold_ticks_reg)
            begin
                hold_count_next = '0;
                bite_next       = 1'b0;
            end
            else
            begin
                hold_count_next = hold_count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW; i++)
            begin
                tap_reg[i] <= '0;
            end
            sum_prev_reg   <= '0;
            sum_prev2_reg  <= '0;
            run_count_reg  <= '0;
            bite_flag_reg  <= 1'b0;
            hold_count_reg <= '0;
            end_count_reg  <= '0;
            off_flag_reg   <= 1'b0;
        end
        else if (advance)
        begin
            tap_reg[0] <= s1_sample_reg;
            for (int i = 1; i < WINDOW; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
            sum_prev_reg   <= sum_next;
            sum_prev2_reg  <= sum_prev_reg;
            run_count_reg  <= run_count_next;
            bite_flag_reg  <= bite_next;
            hold_count_reg <= hold_count_next;
            end_count_reg  <= end_count_next;
            off_flag_reg   <= off_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------
    logic bite_reg;
    logic all_off_reg;
    logic motion_hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            bite_reg       <= bite_next;
            all_off_reg    <= off_next;
            motion_hit_reg <= hit_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign bite       = bite_reg;
    assign all_off    = all_off_reg;
    assign motion_hit = motion_hit_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // A stalled item in the input register is neither lost nor altered.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |=> s1_valid_reg && $stable(s1_sample_reg))
        else $error("input stage dropped or changed a stalled item");

    // A miss always ends the run of hits.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && !hit_next |=> run_count_reg == '0)
        else $error("run count not cleared after a miss");

    // A sample at or below the lift level lowers the off flag and freezes the count.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && !above |=> !off_flag_reg && $stable(end_count_reg))
        else $error("end counter moved while not lifted");

    // The result register empties when drained with nothing behind it.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_ready && !s1_valid_reg |=> !out_valid_reg)
        else $error("result repeated after being taken");

endmodule
